// ===== sv/ake_pkg.sv =====
// Shared types, constants and byte functions for the AES key expansion core.
package ake_pkg;

  localparam int unsigned StoreDepth = 30;
  localparam int unsigned WordsMax   = 60;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadSize  = 2'd1;
  localparam logic [1:0] StatusBadRound = 2'd2;

  localparam logic [1:0] KeyLenInvalid = 2'd3;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StExpand = 5'b00010,
    StEncOut = 5'b00100,
    StDecOut = 5'b01000,
    StErrOut = 5'b10000
  } state_e;

  // Operation request from the sequencer to the word unit.
  typedef struct packed {
    logic       sub;
    logic       rot;
    logic [7:0] rcon;
  } word_op_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int n = 0; n < 4; n++) begin
      if (b[n]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[7:0];
    a1 = w[15:8];
    a2 = w[23:16];
    a3 = w[31:24];
    inv_mix_word[7:0]   = gf_mul(a0, 4'd14) ^ gf_mul(a1, 4'd11) ^ gf_mul(a2, 4'd13)
                        ^ gf_mul(a3, 4'd9);
    inv_mix_word[15:8]  = gf_mul(a0, 4'd9) ^ gf_mul(a1, 4'd14) ^ gf_mul(a2, 4'd11)
                        ^ gf_mul(a3, 4'd13);
    inv_mix_word[23:16] = gf_mul(a0, 4'd13) ^ gf_mul(a1, 4'd9) ^ gf_mul(a2, 4'd14)
                        ^ gf_mul(a3, 4'd11);
    inv_mix_word[31:24] = gf_mul(a0, 4'd11) ^ gf_mul(a1, 4'd13) ^ gf_mul(a2, 4'd9)
                        ^ gf_mul(a3, 4'd14);
  endfunction

endpackage

// ===== sv/ake_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ake_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ake_word_unit.sv =====
// Key word shift line: a window of the last Nk words, one new word per cycle while step_i is high.
module ake_word_unit (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [255:0]         key_i,
  input  logic                 step_i,
  input  logic [2:0]           nk_i,
  input  ake_pkg::word_op_t    op_i,
  output logic [31:0]          new_word_o,
  output logic [31:0]          head_word_o
);
  import ake_pkg::*;

  logic [31:0] win_q [8];
  logic [31:0] win_d [8];
  logic [31:0] last_w;
  logic [31:0] far_w;
  logic [31:0] t;
  logic [31:0] s;

  // The window holds words w[i-Nk] .. w[i-1] in slots 0 .. Nk-1.
  always_comb begin
    last_w = win_q[3'(nk_i - 3'd1)];
    far_w  = win_q[0];
    s = {sbox(last_w[31:24]), sbox(last_w[23:16]), sbox(last_w[15:8]), sbox(last_w[7:0])};
    t = last_w;
    if (op_i.sub) t = s;
    if (op_i.rot) t = {t[7:0], t[31:8]} ^ {24'h0, op_i.rcon};
    new_word_o = far_w ^ t;
  end

  assign head_word_o = win_q[0];

  always_comb begin
    for (int n = 0; n < 8; n++) win_d[n] = win_q[n];
    if (load_i) begin
      for (int n = 0; n < 8; n++) win_d[n] = key_i[32*n +: 32];
    end else if (step_i) begin
      for (int n = 0; n < 7; n++) begin
        win_d[n] = (3'(n) == 3'(nk_i - 3'd1)) ? new_word_o : win_q[n+1];
      end
      win_d[7] = new_word_o;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 8; n++) win_q[n] <= win_d[n];
  end

endmodule

// ===== sv/aes_key_expansion_core.sv =====
// AES key expansion top level: sequencer, word shift line, key store and output register.
//
//  Channel | Dir | tdata fields (low bit first)                          | tuser / tlast
//  s_axis  | in  | key_bytes_0_7..key_bytes_24_31, key_length_code,      | -
//          |     | rounds_requested                                      |
//  m_axis  | out | round_key_low, round_key_high, round_index            | tuser: schedule_kind,
//          |     |                                                       | status; tlast
//
// One key word is produced per cycle by the word shift line, pairs of words go to the
// store. Expansion runs Nk extra steps to flush the window. Each round key is then read
// as two store words, low then high, and registered into the output once the high word
// has been read and the output register is free. An invalid key or round request gives a
// single error result. Reset clears the control state only; a stalled output holds its
// transfer and the sequencer waits for it.
module aes_key_expansion_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_bytes_0_7[63:0], key_bytes_8_15[127:64], key_bytes_16_23[191:128],
  // key_bytes_24_31[255:192], key_length_code[257:256], rounds_requested[261:258]
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // round_key_low[63:0], round_key_high[127:64], round_index[131:128]
  output logic [135:0] m_axis_tdata,
  // schedule_kind[0], status[2:1]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import ake_pkg::*;

  state_e      state_q, state_d;
  logic [2:0]  nk_q;
  logic [3:0]  nr_q;
  logic [5:0]  widx_q;    // index of the word being produced
  logic [2:0]  mod_q;     // widx mod Nk
  logic [3:0]  rc_q;      // round constant position
  logic [31:0] even_q;    // even word waiting for its pair
  logic [3:0]  ridx_q;    // result index within the current schedule
  logic [1:0]  phase_q;   // 0 issue low read, 1 issue high read, 2 capture high
  logic [63:0] lo_q;
  logic        ovalid_q;
  logic [135:0] odata_q;
  logic [2:0]  ouser_q;
  logic        olast_q;
  logic [1:0]  err_q;     // error status captured with the rejected key

  logic [1:0]  code;
  logic [3:0]  req;
  logic [3:0]  nr_calc;
  word_op_t    op;
  logic [31:0] new_word;
  logic [31:0] head_word;
  logic        load, step;
  logic        we;
  logic [4:0]  waddr, raddr;
  logic [63:0] rdata;
  logic [7:0]  rcon;
  logic [3:0]  src;
  logic        out_free;
  logic        mix;
  logic [63:0] hi_x, lo_x;

  assign code    = s_axis_tdata[257:256];
  assign req     = s_axis_tdata[261:258];
  assign nr_calc = 4'd10 + {1'b0, code, 1'b0};

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;
  assign load = s_axis_tvalid && s_axis_tready;
  assign step = (state_q == StExpand);
  assign out_free = !ovalid_q || m_axis_tready;

  always_comb begin
    unique case (rc_q)
      4'd0: rcon = 8'h01;
      4'd1: rcon = 8'h02;
      4'd2: rcon = 8'h04;
      4'd3: rcon = 8'h08;
      4'd4: rcon = 8'h10;
      4'd5: rcon = 8'h20;
      4'd6: rcon = 8'h40;
      4'd7: rcon = 8'h80;
      4'd8: rcon = 8'h1b;
      4'd9: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  end

  always_comb begin
    op.sub  = (mod_q == 3'd0) || (nk_q == 3'd0 && mod_q == 3'd4);
    op.rot  = (mod_q == 3'd0);
    op.rcon = rcon;
  end

  // nk_q holds Nk mod 8, so 0 encodes a 256 bit key (Nk of 8).
  ake_word_unit u_word (
    .clk_i       (clk_i),
    .load_i      (load),
    .key_i       (s_axis_tdata[255:0]),
    .step_i      (step),
    .nk_i        (nk_q),
    .op_i        (op),
    .new_word_o  (new_word),
    .head_word_o (head_word)
  );

  // The key words are written as the window shifts them out at slot 0, then new words.
  logic [31:0] wr_word;
  logic [5:0]  wr_idx;
  logic [5:0]  nk6;
  logic [5:0]  total;
  assign nk6    = (nk_q == 3'd0) ? 6'd8 : {3'b000, nk_q};
  assign total  = {nr_q, 2'b00} + 6'd4;
  assign wr_idx = widx_q - nk6;
  assign wr_word = head_word;
  assign we = step && wr_idx[0];
  assign waddr = wr_idx[5:1];

  // The high word stays addressed while a result waits for the output register.
  always_comb begin
    src = (state_q == StDecOut) ? (nr_q - ridx_q) : ridx_q;
    raddr = {src, phase_q != 2'd0};
  end

  ake_ram #(.Width(64), .Depth(StoreDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({wr_word, even_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mix  = (state_q == StDecOut) && ridx_q != 4'd0 && ridx_q != nr_q;
  assign lo_x = mix ? {inv_mix_word(lo_q[63:32]), inv_mix_word(lo_q[31:0])} : lo_q;
  assign hi_x = mix ? {inv_mix_word(rdata[63:32]), inv_mix_word(rdata[31:0])} : rdata;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (load) begin
          if (code == KeyLenInvalid) state_d = StErrOut;
          else if (req != 4'd0 && req != nr_calc) state_d = StErrOut;
          else state_d = StExpand;
        end
      end
      // Run Nk extra steps so the last words are flushed out of slot 0.
      StExpand: if (widx_q == total + nk6 - 6'd1) state_d = StEncOut;
      StEncOut: if (phase_q == 2'd2 && out_free && ridx_q == nr_q) state_d = StDecOut;
      StDecOut: if (phase_q == 2'd2 && out_free && ridx_q == nr_q) state_d = StIdle;
      StErrOut: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      phase_q  <= 2'd0;
      ridx_q   <= 4'd0;
      widx_q   <= 6'd0;
      mod_q    <= 3'd0;
      rc_q     <= 4'd0;
      nk_q     <= 3'd4;
      nr_q     <= 4'd10;
    end else begin
      state_q <= state_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (load) begin
            nk_q   <= 3'(4 + 2 * code);
            nr_q   <= nr_calc;
            widx_q <= (code == 2'd2) ? 6'd8 : {3'b000, 3'(4 + 2 * code)};
            mod_q  <= 3'd0;
            rc_q   <= 4'd0;
            ridx_q <= 4'd0;
            phase_q <= 2'd0;
          end
        end
        StExpand: begin
          widx_q <= widx_q + 6'd1;
          if (mod_q == 3'(nk6 - 6'd1)) begin
            mod_q <= 3'd0;
            rc_q  <= rc_q + 4'd1;
          end else begin
            mod_q <= mod_q + 3'd1;
          end
        end
        StEncOut, StDecOut: begin
          if (phase_q == 2'd2) begin
            if (out_free) begin
              ovalid_q <= 1'b1;
              phase_q  <= 2'd0;
              ridx_q   <= (ridx_q == nr_q) ? 4'd0 : ridx_q + 4'd1;
            end
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        StErrOut: if (out_free) ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) err_q <= (code == KeyLenInvalid) ? StatusBadSize : StatusBadRound;
    if (step && !wr_idx[0]) even_q <= wr_word;
    if ((state_q == StEncOut || state_q == StDecOut) && phase_q == 2'd1) lo_q <= rdata;
    if (state_q == StErrOut && out_free) begin
      odata_q <= '0;
      ouser_q <= {err_q, 1'b0};
      olast_q <= 1'b1;
    end else if ((state_q == StEncOut || state_q == StDecOut) && phase_q == 2'd2
                 && out_free) begin
      odata_q <= {4'd0, ridx_q, hi_x, lo_x};
      ouser_q <= {StatusOk, state_q == StDecOut};
      olast_q <= (state_q == StDecOut) && ridx_q == nr_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the AES key expansion core.
`timescale 1ns / 100ps

module testbench;
  import ake_pkg::*;

  typedef struct packed {
    logic [3:0]   rounds;
    logic [1:0]   len_code;
    logic [255:0] key;
  } key_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [3:0]  idx;
    logic        kind;
    logic [1:0]  status;
    logic        last;
  } round_key_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [263:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  aes_key_expansion_core dut (.*);

  key_req_t   pending_keys[$];
  round_key_t expected_keys[$];
  int         errors;
  int         cycles;
  int         send_wait;
  int         recv_wait;
  bit         in_accepted;

  localparam int CycleLimit = 2000000;

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= a;
      a = mul2(a);
    end
    return acc;
  endfunction

  // S-box computed as the field inverse (x^254) followed by the affine map.
  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] sq;
    logic [7:0] inv;
    logic [7:0] b;
    sq = field_mul(x, x);
    inv = sq;
    for (int n = 0; n < 6; n++) begin
      sq = field_mul(sq, sq);
      inv = field_mul(inv, sq);
    end
    b = inv;
    for (int n = 1; n <= 4; n++) b ^= (inv << n) | (inv >> (8 - n));
    return b ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
    for (int n = 0; n < 4; n++) w[8*n +: 8] = sub_byte(w[8*n +: 8]);
    return w;
  endfunction

  function automatic logic [31:0] unmix_column(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [31:0] r;
    m = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int n = 0; n < 4; n++) a[n] = w[8*n +: 8];
    for (int row = 0; row < 4; row++) begin
      r[8*row +: 8] = 8'h00;
      for (int col = 0; col < 4; col++)
        r[8*row +: 8] ^= field_mul(a[col], m[(col - row + 4) % 4]);
    end
    return r;
  endfunction

  task automatic push_result(input logic [63:0] lo, input logic [63:0] hi,
                             input int idx, input logic kind, input logic [1:0] st,
                             input logic last);
    round_key_t r;
    r.lo = lo; r.hi = hi; r.idx = 4'(idx); r.kind = kind; r.status = st; r.last = last;
    expected_keys.push_back(r);
  endtask

  task automatic expand_schedule(input key_req_t req);
    logic [31:0] w [60];
    logic [31:0] t;
    logic [31:0] c [4];
    logic [7:0]  rc;
    int nk, nr, total;
    if (req.len_code == KeyLenInvalid) begin
      push_result('0, '0, 0, 1'b0, StatusBadSize, 1'b1);
      return;
    end
    nk = 4 + 2 * req.len_code;
    nr = 10 + 2 * req.len_code;
    if (req.rounds != 0 && req.rounds != nr) begin
      push_result('0, '0, 0, 1'b0, StatusBadRound, 1'b1);
      return;
    end
    total = 4 * (nr + 1);
    for (int i = 0; i < nk; i++) w[i] = req.key[32*i +: 32];
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_bytes32(t);
        t = {t[7:0], t[31:8]};
        t ^= {24'h0, rc};
        rc = mul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes32(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= nr; r++)
      push_result({w[4*r+1], w[4*r]}, {w[4*r+3], w[4*r+2]}, r, 1'b0, StatusOk, 1'b0);
    for (int k = 0; k <= nr; k++) begin
      for (int n = 0; n < 4; n++) begin
        c[n] = w[4*(nr-k) + n];
        if (k != 0 && k != nr) c[n] = unmix_column(c[n]);
      end
      push_result({c[1], c[0]}, {c[3], c[2]}, k, 1'b1, StatusOk, k == nr);
    end
  endtask

  function automatic logic [255:0] rand_key();
    logic [255:0] k;
    for (int n = 0; n < 8; n++) k[32*n +: 32] = $urandom;
    return k;
  endfunction

  task automatic queue_key(input logic [255:0] key, input logic [1:0] len,
                           input logic [3:0] rounds);
    key_req_t r;
    r.key = key; r.len_code = len; r.rounds = rounds;
    pending_keys.push_back(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: draws a gap after each accepted key, then holds valid until the transfer.
  always @(negedge clk_i) begin
    if (in_accepted) begin
      expand_schedule(key_req_t'(s_axis_tdata[261:0]));
      void'(pending_keys.pop_front());
      send_wait = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) send_wait = 0;
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_accepted) begin
      s_axis_tvalid <= 1'b1;
    end else if (send_wait > 0) begin
      send_wait--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_keys.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {2'b00, pending_keys[0]};
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver stalls are redrawn after each transfer.
  always @(negedge clk_i) begin
    if (recv_wait > 0) begin
      recv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    round_key_t exp_r;
    cycles++;
    // The input transfer is sampled here and predicted at the following falling edge.
    in_accepted = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
      if (expected_keys.size() == 0) begin
        $error("unexpected transfer: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_keys.pop_front();
        if (m_axis_tdata[63:0] !== exp_r.lo) begin
          $error("round_key_low: expected %h actual %h", exp_r.lo, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] !== exp_r.hi) begin
          $error("round_key_high: expected %h actual %h", exp_r.hi, m_axis_tdata[127:64]);
          errors++;
        end
        if (m_axis_tdata[131:128] !== exp_r.idx) begin
          $error("round_index: expected %0d actual %0d", exp_r.idx, m_axis_tdata[131:128]);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_r.kind) begin
          $error("schedule_kind: expected %0d actual %0d", exp_r.kind, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[2:1] !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, m_axis_tuser[2:1]);
          errors++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last_of_run: expected %0d actual %0d", exp_r.last, m_axis_tlast);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] len;
    logic [3:0] rounds;
    errors = 0;
    cycles = 0;
    send_wait = 0;
    recv_wait = 0;
    in_accepted = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;

    // Standard test key, then all-zero, all-one and random keys at each length.
    queue_key(256'h0f0e0d0c0b0a09080706050403020100_0f0e0d0c0b0a09080706050403020100,
              2'd0, 4'd0);
    for (int l = 0; l < 3; l++) begin
      queue_key('0, 2'(l), 4'd0);
      queue_key('1, 2'(l), 4'd0);
      queue_key(rand_key(), 2'(l), 4'(10 + 2 * l));
    end
    // Bad size, with all-ones and all-zero fields, and round counts that mismatch the length.
    queue_key('1, KeyLenInvalid, 4'd15);
    queue_key('0, KeyLenInvalid, 4'd0);
    queue_key(rand_key(), 2'd0, 4'd12);
    queue_key(rand_key(), 2'd1, 4'd14);
    queue_key(rand_key(), 2'd2, 4'd10);
    queue_key(rand_key(), 2'd0, 4'd15);
    queue_key(rand_key(), 2'd2, 4'd1);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int n = 0; n < 220; n++) begin
      len = 2'($urandom_range(0, 2));
      rounds = 4'd0;
      case ($urandom_range(0, 9))
        0: len = KeyLenInvalid;
        1: rounds = 4'($urandom_range(0, 15));
        2, 3, 4: rounds = 4'(10 + 2 * len);
        default: rounds = 4'd0;
      endcase
      if (len == KeyLenInvalid) rounds = 4'($urandom_range(0, 15));
      queue_key(rand_key(), len, rounds);
      // Keep the queue short so random gaps interleave with output traffic.
      while (pending_keys.size() > 4) @(posedge clk_i);
    end

    wait (pending_keys.size() == 0 && !s_axis_tvalid);
    @(negedge clk_i);
    wait (expected_keys.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
